@@ src/ale_pkg.sv @@
// Shared field widths, operation codes and status codes of the array list engine.
// No dependencies; the engine and the testbench import this package.
`timescale 1ns / 1ps

package ale_pkg;

    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int ST_W   = 3;
    localparam int FPOS_W = 7;
    localparam int CNT_W  = 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [ST_W-1:0] STAT_OK     = 3'd0;
    localparam logic [ST_W-1:0] STAT_FULL   = 3'd1;
    localparam logic [ST_W-1:0] STAT_BADPOS = 3'd2;
    localparam logic [ST_W-1:0] STAT_EMPTY  = 3'd3;
    localparam logic [ST_W-1:0] STAT_MISS   = 3'd4;

endpackage

@@ src/array_list_engine.sv @@
// Array list engine top level: command sequencer, count and result register.
// Depends on ale_pkg and ale_ram.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: op, insert_value,
//   position, search_key. Output channel (out_valid/out_ready) returns one
//   result beat per command: status, found_position, entry_count.
//   Commands run one at a time; in_ready is high only while the sequencer idles.
//   All moves and compares go through the single read and write port of the
//   entry store, one entry per cycle, with registered read data.
//   Clear, rejected commands, search of an empty list and delete of the last
//   entry go straight to the result; insert at the end writes the value at once;
//   insert at p shifts entries p to n-1 up by one, from the top down, then
//   writes the value at p; delete at p shifts entries p+1 to n-1 down by one;
//   search reads entries from 0 upward and stops at the first match or after
//   the last entry.
//   A finished result waits in the output register while the next command is
//   taken; if the receiver still stalls when that one finishes, the sequencer
//   holds until the output register frees. Reset empties the list; the store
//   needs no clearing pass.
module array_list_engine #(
    parameter int DEPTH = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ale_pkg::OP_W-1:0]    op,
    input  logic signed [ale_pkg::VAL_W-1:0] insert_value,
    input  logic [ale_pkg::POS_W-1:0]   position,
    input  logic signed [ale_pkg::VAL_W-1:0] search_key,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ale_pkg::ST_W-1:0]    status,
    output logic [ale_pkg::FPOS_W-1:0]  found_position,
    output logic [ale_pkg::CNT_W-1:0]   entry_count
);

    import ale_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_SRCH,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              issuing_reg, issuing_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]     rd_last_reg, rd_last_next;
    logic [AW-1:0]     end_ptr_reg, end_ptr_next;
    logic [AW-1:0]     put_ptr_reg, put_ptr_next;
    logic              shift_up_reg, shift_up_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [VAL_W-1:0]  key_reg, key_next;
    logic [ST_W-1:0]   stat_reg, stat_next;
    logic [AW-1:0]     found_reg, found_next;
    logic              out_valid_reg, out_valid_next;
    logic [ST_W-1:0]   out_stat_reg, out_stat_next;
    logic [FPOS_W-1:0] out_found_reg, out_found_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [VAL_W-1:0]  mem_wr_data;
    logic              mem_rd_en;
    logic [VAL_W-1:0]  mem_rd_data;

    logic              accept;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     count_x;
    logic [XW-1:0]     found_x;
    logic [CW-1:0]     cnt_m1;
    logic [AW-1:0]     pos_a;

    assign accept  = in_valid && in_ready;
    assign pos_x   = XW'(position);
    assign count_x = XW'(count_reg);
    assign found_x = XW'(found_reg);
    assign cnt_m1  = count_reg - CW'(1);
    assign pos_a   = pos_x[AW-1:0];

    ale_ram #(
        .DEPTH(DEPTH),
        .WIDTH(VAL_W)
    ) u_ram (
        .clk    (clk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (mem_rd_en),
        .rd_addr(rd_ptr_reg),
        .rd_data(mem_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issuing_next   = issuing_reg;
        pend_next      = pend_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_last_next   = rd_last_reg;
        end_ptr_next   = end_ptr_reg;
        put_ptr_next   = put_ptr_reg;
        shift_up_next  = shift_up_reg;
        value_next     = value_reg;
        key_next       = key_reg;
        stat_next      = stat_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_stat_next  = out_stat_reg;
        out_found_next = out_found_reg;
        out_count_next = out_count_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = shift_up_reg ? (rd_last_reg + AW'(1)) : (rd_last_reg - AW'(1));
        mem_wr_data    = mem_rd_data;
        mem_rd_en      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next   = insert_value;
                    key_next     = search_key;
                    put_ptr_next = pos_a;
                    found_next   = '0;
                    stat_next    = STAT_OK;
                    pend_next    = 1'b0;
                    issuing_next = 1'b1;
                    state_next   = S_DONE;
                    case (op)
                        OP_INSERT:
                        begin
                            shift_up_next = 1'b1;
                            if (count_x == XW'(DEPTH))
                            begin
                                stat_next = STAT_FULL;
                            end
                            else if (pos_x > count_x)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                if (pos_x == count_x)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    rd_ptr_next  = cnt_m1[AW-1:0];
                                    end_ptr_next = pos_a;
                                    state_next   = S_SHIFT;
                                end
                            end
                        end
                        OP_DELETE:
                        begin
                            shift_up_next = 1'b0;
                            if (count_reg == '0)
                            begin
                                stat_next = STAT_EMPTY;
                            end
                            else if (pos_x >= count_x)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                if (pos_x != XW'(cnt_m1))
                                begin
                                    rd_ptr_next  = pos_a + AW'(1);
                                    end_ptr_next = cnt_m1[AW-1:0];
                                    state_next   = S_SHIFT;
                                end
                            end
                        end
                        OP_SEARCH:
                        begin
                            shift_up_next = 1'b0;
                            if (count_reg == '0)
                            begin
                                stat_next = STAT_MISS;
                            end
                            else
                            begin
                                rd_ptr_next  = '0;
                                end_ptr_next = cnt_m1[AW-1:0];
                                state_next   = S_SRCH;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end

            S_SHIFT, S_SRCH:
            begin
                if (issuing_reg)
                begin
                    mem_rd_en    = 1'b1;
                    rd_last_next = rd_ptr_reg;
                    pend_next    = 1'b1;
                    if (rd_ptr_reg == end_ptr_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = shift_up_reg ? (rd_ptr_reg - AW'(1))
                                                   : (rd_ptr_reg + AW'(1));
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (state_reg == S_SHIFT)
                begin
                    mem_wr_en = pend_reg;
                    if (!issuing_reg && pend_reg)
                    begin
                        state_next = shift_up_reg ? S_PUT : S_DONE;
                    end
                end
                else if (pend_reg && (mem_rd_data == key_reg))
                begin
                    found_next   = rd_last_reg;
                    issuing_next = 1'b0;
                    pend_next    = 1'b0;
                    state_next   = S_DONE;
                end
                else if (!issuing_reg && pend_reg)
                begin
                    stat_next  = STAT_MISS;
                    state_next = S_DONE;
                end
            end

            S_PUT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = put_ptr_reg;
                mem_wr_data = value_reg;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_found_next = found_x[FPOS_W-1:0];
                    out_count_next = count_x[CNT_W-1:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issuing_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_stat_reg  <= '0;
            out_found_reg <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issuing_reg   <= issuing_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_stat_reg  <= out_stat_next;
            out_found_reg <= out_found_next;
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        rd_last_reg   <= rd_last_next;
        end_ptr_reg   <= end_ptr_next;
        put_ptr_reg   <= put_ptr_next;
        shift_up_reg  <= shift_up_next;
        value_reg     <= value_next;
        key_reg       <= key_next;
        stat_reg      <= stat_next;
        found_reg     <= found_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_stat_reg;
    assign found_position = out_found_reg;
    assign entry_count    = out_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_x <= XW'(DEPTH))
        else $error("entry count above depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> (count_reg == $past(count_reg)))
        else $error("entry count changed without a command beat");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !mem_wr_en)
        else $error("store written outside a command");

    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg != STAT_OK) |-> (out_found_reg == '0))
        else $error("found position set on a failed command");
`endif

endmodule

@@ src/ale_ram.sv @@
// Single write port, single read port entry store with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ale_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ dv/tb_array_list_engine.sv @@
// Self-checking testbench for array_list_engine: random and directed list commands.
// Depends on ale_pkg and the array_list_engine RTL; a class mirrors the list to
// predict every result beat.
`timescale 1ns / 1ps

module tb_array_list_engine;
    import ale_pkg::*;

    localparam int DEPTH          = 128;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int IDLE_PCT       = 23;
    localparam int QUIET_FIRST    = 700;
    localparam int QUIET_LAST     = 1000;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [FPOS_W-1:0] fpos;
        logic [CNT_W-1:0]  count;
    } list_result_t;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} traffic_mode_t;

    class list_mirror;
        logic signed [VAL_W-1:0] entries[$];
        list_result_t            pending[$];
        int                      errors;

        function void note_command(logic [OP_W-1:0] c_op, logic signed [VAL_W-1:0] c_value,
                                   logic [POS_W-1:0] c_pos, logic signed [VAL_W-1:0] c_key);
            list_result_t r;
            int n;
            int i;
            n = entries.size();
            r.status = STAT_OK;
            r.fpos   = '0;
            case (c_op)
                OP_INSERT:
                begin
                    if (n >= DEPTH)
                        r.status = STAT_FULL;
                    else if (c_pos > n)
                        r.status = STAT_BADPOS;
                    else
                        entries.insert(c_pos, c_value);
                end
                OP_DELETE:
                begin
                    if (n == 0)
                        r.status = STAT_EMPTY;
                    else if (c_pos >= n)
                        r.status = STAT_BADPOS;
                    else
                        entries.delete(c_pos);
                end
                OP_SEARCH:
                begin
                    r.status = STAT_MISS;
                    for (i = 0; i < n; i++)
                    begin
                        if (entries[i] == c_key)
                        begin
                            r.status = STAT_OK;
                            r.fpos   = FPOS_W'(i);
                            break;
                        end
                    end
                end
                default:
                    entries.delete();
            endcase
            r.count = CNT_W'(entries.size());
            pending.push_back(r);
        endfunction

        function void check_result(logic [ST_W-1:0] st, logic [FPOS_W-1:0] fp,
                                   logic [CNT_W-1:0] cnt);
            list_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: status %0d pos %0d count %0d",
                             st, fp, cnt);
                return;
            end
            want = pending.pop_front();
            if (st !== want.status || fp !== want.fpos || cnt !== want.count)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                             want.status, want.fpos, want.count, st, fp, cnt);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [OP_W-1:0]          op = OP_SEARCH;
    logic signed [VAL_W-1:0]  insert_value = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [VAL_W-1:0]  search_key = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [ST_W-1:0]          status;
    logic [FPOS_W-1:0]        found_position;
    logic [CNT_W-1:0]         entry_count;

    list_mirror mirror = new();
    logic       quiet = 1'b0;
    int         sent = 0;
    int         stuck_cycles = 0;

    array_list_engine #(.DEPTH(DEPTH)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .insert_value   (insert_value),
        .position       (position),
        .search_key     (search_key),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Sample both channels mid-cycle; values hold until the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                mirror.check_result(status, found_position, entry_count);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_array_list_engine NOT OK");
                $finish;
            end
        end
    end

    task automatic send_command(input logic [OP_W-1:0] c_op,
                                input logic signed [VAL_W-1:0] c_value,
                                input logic [POS_W-1:0] c_pos,
                                input logic signed [VAL_W-1:0] c_key);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= c_op;
        insert_value <= c_value;
        position     <= c_pos;
        search_key   <= c_key;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        mirror.note_command(c_op, c_value, c_pos, c_key);
        @(posedge clk);
        sent++;
    endtask

    function automatic logic [OP_W-1:0] pick_op(traffic_mode_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  return (roll < 85) ? OP_INSERT : OP_SEARCH;
            MODE_DRAIN: return (roll < 75) ? OP_DELETE : (roll < 95) ? OP_SEARCH : OP_INSERT;
            MODE_MIXED: return (roll < 36) ? OP_INSERT : (roll < 66) ? OP_DELETE :
                               (roll < 97) ? OP_SEARCH : OP_CLEAR;
            default:    return OP_W'($urandom_range(0, 3));
        endcase
    endfunction

    initial
    begin
        traffic_mode_t           mode;
        logic [OP_W-1:0]         c_op;
        logic [POS_W-1:0]        c_pos;
        logic signed [VAL_W-1:0] c_value;
        logic signed [VAL_W-1:0] c_key;
        int                      n;
        int                      span;
        bit                      first;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, bad positions, extreme values, duplicates, stale words after clear.
        send_command(OP_SEARCH, $urandom, POS_W'($urandom), 32'sd0);
        send_command(OP_DELETE, $urandom, 8'd0, $urandom);
        send_command(OP_DELETE, $urandom, 8'd255, $urandom);
        send_command(OP_INSERT, 32'sd9, 8'd1, $urandom);
        send_command(OP_INSERT, 32'sd9, 8'd255, $urandom);
        send_command(OP_INSERT, 32'sh8000_0000, 8'd0, $urandom);
        send_command(OP_INSERT, 32'sh7fff_ffff, 8'd1, $urandom);
        send_command(OP_INSERT, -32'sd1, 8'd0, $urandom);
        send_command(OP_INSERT, 32'sd0, 8'd1, $urandom);
        send_command(OP_INSERT, -32'sd1, 8'd4, $urandom);
        send_command(OP_SEARCH, $urandom, POS_W'($urandom), -32'sd1);
        send_command(OP_SEARCH, $urandom, POS_W'($urandom), 32'sh7fff_ffff);
        send_command(OP_SEARCH, $urandom, POS_W'($urandom), 32'sd12345);
        send_command(OP_DELETE, $urandom, 8'd5, $urandom);
        send_command(OP_DELETE, $urandom, 8'd2, $urandom);
        send_command(OP_DELETE, $urandom, 8'd3, $urandom);
        send_command(OP_DELETE, $urandom, 8'd0, $urandom);
        send_command(OP_INSERT, 32'sd3, 8'd3, $urandom);
        send_command(OP_CLEAR, $urandom, POS_W'($urandom), $urandom);
        send_command(OP_SEARCH, $urandom, POS_W'($urandom), 32'sh7fff_ffff);
        send_command(OP_DELETE, $urandom, 8'd0, $urandom);
        send_command(OP_INSERT, 32'sd5, 8'd0, $urandom);
        send_command(OP_SEARCH, $urandom, POS_W'($urandom), 32'sd5);

        // Run episodes of biased traffic; the first one fills the list past full.
        first = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            mode  = first ? MODE_FILL : traffic_mode_t'($urandom_range(0, 3));
            span  = first ? 170 : (mode == MODE_NOISE) ? $urandom_range(10, 40) :
                                                          $urandom_range(20, 160);
            first = 1'b0;
            repeat (span)
            begin
                if (sent >= RANDOM_ITEMS)
                    break;
                c_op = pick_op(mode);
                n    = mirror.entries.size();
                if (mode == MODE_NOISE || $urandom_range(0, 99) < 8)
                    c_pos = POS_W'($urandom_range(0, 255));
                else if (c_op == OP_DELETE && n > 0)
                    c_pos = POS_W'($urandom_range(0, n - 1));
                else if ($urandom_range(0, 3) == 0)
                    c_pos = POS_W'(n);
                else
                    c_pos = POS_W'($urandom_range(0, n));
                if ($urandom_range(0, 99) < 40)
                    c_value = int'($urandom_range(0, 7)) - 3;
                else
                    c_value = $urandom;
                if (n > 0 && $urandom_range(0, 99) < 70)
                    c_key = mirror.entries[$urandom_range(0, n - 1)];
                else if ($urandom_range(0, 99) < 30)
                    c_key = int'($urandom_range(0, 7)) - 3;
                else
                    c_key = $urandom;
                send_command(c_op, c_value, c_pos, c_key);
                quiet <= (sent >= QUIET_FIRST && sent < QUIET_LAST);
            end
        end
        in_valid <= 1'b0;

        while (mirror.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mirror.errors == 0 && mirror.pending.size() == 0)
            $display("tb_array_list_engine OK");
        else
            $display("tb_array_list_engine NOT OK");
        $finish;
    end

endmodule

@@ array_list_engine.f @@
src/ale_pkg.sv
src/ale_ram.sv
src/array_list_engine.sv
dv/tb_array_list_engine.sv
